[src/bcr_pkg.sv]
// ----------------------------------------------------------------------------
// bcr_pkg
// Shared types and constants of the task bid cluster router.
// ----------------------------------------------------------------------------
`default_nettype none

package bcr_pkg;

   localparam int DEN_W      = 11;
   localparam int WDIV_W     = 50;
   localparam int CDIV_W     = 13;
   localparam int DIV_STAGES = 13;
   localparam int LAT        = DIV_STAGES + 5;

   localparam logic [24:0] SLICE_P_NS = 25'd20000000;
   localparam logic [31:0] IDLE_CLAMP = 32'd1000000000;
   localparam logic [10:0] CAP_DEFAULT    = 11'd1024;
   localparam logic [15:0] COST_P_DEFAULT = 16'd1024;
   localparam logic [15:0] COST_E_DEFAULT = 16'd512;
   localparam logic [62:0] KEY_BIAS = 63'h4000_0000_0000_0000;
   localparam logic signed [51:0] BID_MAX = 52'sd4398046511103;
   localparam logic signed [51:0] BID_MIN = -52'sd4398046511104;

   typedef enum logic [1:0] {
      CSR_PERF_CAP = 2'd0,
      CSR_EFF_CAP  = 2'd1,
      CSR_PERF_COST = 2'd2,
      CSR_EFF_COST = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      Q_PERF    = 2'd0,
      Q_EFF     = 2'd1,
      Q_STARVED = 2'd2
   } queue_type;

   typedef struct packed {
      logic signed [42:0] phi_p;
      logic [40:0]        cost_e;
      logic               lp2;
      logic [37:0]        budget;
      logic [37:0]        cap;
   } side_type;

endpackage

`default_nettype wire

[src/bcr_div.sv]
// ----------------------------------------------------------------------------
// bcr_div
// Pipelined restoring divider, ceil(DW/STAGES) quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_div #(
   parameter int DW     = 50,
   parameter int STAGES = 13
) (
   input  wire logic                        clock,
   input  wire logic                        adv,
   input  wire logic [DW-1:0]               dividend,
   input  wire logic [bcr_pkg::DEN_W-1:0]   divisor,
   output logic      [DW-1:0]               quotient
);

   localparam int BPS = (DW + STAGES - 1) / STAGES;
   localparam int PW  = BPS * STAGES;
   localparam int RW  = bcr_pkg::DEN_W + 1;

   logic [RW-1:0]             rem_ff [STAGES];
   logic [PW-1:0]             num_ff [STAGES];
   logic [bcr_pkg::DEN_W-1:0] den_ff [STAGES];

   for (genvar g = 0; g < STAGES; g++) begin : g_stage
      logic [RW-1:0]             rem_src;
      logic [PW-1:0]             num_src;
      logic [bcr_pkg::DEN_W-1:0] den_src;
      logic [RW-1:0]             rem_in;
      logic [PW-1:0]             num_in;

      if (g == 0) begin : g_head
         assign rem_src = '0;
         assign num_src = PW'(dividend);
         assign den_src = divisor;
      end else begin : g_body
         assign rem_src = rem_ff[g-1];
         assign num_src = num_ff[g-1];
         assign den_src = den_ff[g-1];
      end

      always_comb begin
         rem_in = rem_src;
         num_in = num_src;
         for (int b = 0; b < BPS; b++) begin
            rem_in = {rem_in[RW-2:0], num_in[PW-1]};
            num_in = {num_in[PW-2:0], 1'b0};
            if (rem_in >= {1'b0, den_src}) begin
               rem_in    = rem_in - {1'b0, den_src};
               num_in[0] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[g] <= rem_in;
            num_ff[g] <= num_in;
            den_ff[g] <= den_src;
         end
      end
   end

   assign quotient = num_ff[STAGES-1][DW-1:0];

endmodule

`default_nettype wire

[src/task_bid_cluster_router.sv]
// ----------------------------------------------------------------------------
// task_bid_cluster_router
// Per-task enqueue routing: refill, cluster auction, contract, key, queue.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one enqueue request per item; is_wakeup rides in req_tuser.
//   rsp_* returns one routing result per item; flags and queue ride in tuser.
//   csr_* writes the capacity and cost registers; always ready. The user must
//   write them only while no item is in flight; the block does not enforce it.
// Pipeline: req accept to rsp_tvalid runs through the two 13-stage
//   pipelined dividers (efficiency value scaling and contract length).
// Throughput: one item per cycle unless the output stalls; no bubbles between items.
// Reset: clears all valid bits and loads the register defaults; the block
//   accepts items in the first cycle after reset.
// Stall: when rsp_tready is low with a result waiting, the whole pipeline
//   holds and req_tready drops in the same cycle; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module task_bid_cluster_router #(
   parameter int CONTRACT_LIMIT = 32
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // task_weight[13:0] length_estimate[38:14] budget_now[76:39]
   // budget_cap[114:77] idle_time[146:115] zero[151:147]
   input  wire logic [151:0] req_tdata,
   // is_wakeup[0]
   input  wire logic [0:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // bid_value[42:0] contract_quanta[47:43] sort_key[110:48]
   // budget_out[148:111] zero[151:149]
   output logic [151:0]      rsp_tdata,
   // to_perf[0] target_queue[2:1] eff_slice[3]
   output logic [3:0]        rsp_tuser,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_index,
   input  wire logic [15:0]  csr_data
);

   localparam int LAT = bcr_pkg::LAT;
   localparam logic [12:0] M_SAT = 13'(CONTRACT_LIMIT - 1);

   logic [10:0] perf_cap_ff, eff_cap_ff;
   logic [15:0] perf_cost_ff, eff_cost_ff;
   logic [10:0] mx, mc;
   logic [15:0] cp, ce;
   logic        adv;
   logic [LAT-1:0] vld_ff, vld_in;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         perf_cap_ff  <= bcr_pkg::CAP_DEFAULT;
         eff_cap_ff   <= bcr_pkg::CAP_DEFAULT;
         perf_cost_ff <= bcr_pkg::COST_P_DEFAULT;
         eff_cost_ff  <= bcr_pkg::COST_E_DEFAULT;
      end else if (csr_valid) begin
         unique case (bcr_pkg::csr_index_type'(csr_index))
            bcr_pkg::CSR_PERF_CAP:  perf_cap_ff  <= csr_data[10:0];
            bcr_pkg::CSR_EFF_CAP:   eff_cap_ff   <= csr_data[10:0];
            bcr_pkg::CSR_PERF_COST: perf_cost_ff <= csr_data;
            bcr_pkg::CSR_EFF_COST:  eff_cost_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   assign mx = (perf_cap_ff != '0) ? perf_cap_ff : bcr_pkg::CAP_DEFAULT;
   assign mc = (eff_cap_ff != '0) ? eff_cap_ff : mx;
   assign cp = (perf_cost_ff != '0) ? perf_cost_ff : bcr_pkg::COST_P_DEFAULT;
   assign ce = (eff_cost_ff != '0) ? eff_cost_ff : bcr_pkg::COST_E_DEFAULT;

   assign adv        = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = adv;

   always_comb begin
      vld_in = {vld_ff[LAT-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // stage 1: normalize, multiply
   logic [13:0] w_raw, w1;
   logic [24:0] len_raw, len1;
   logic [31:0] idle_raw;
   logic [29:0] idle_c;
   logic [38:0] wsp_ff;
   logic [40:0] costp_ff, coste_ff;
   logic [43:0] rprod_ff;
   logic        wake_ff, lp2_ff;
   logic [37:0] bud1_ff, cap1_ff;

   assign w_raw    = req_tdata[13:0];
   assign len_raw  = req_tdata[38:14];
   assign idle_raw = req_tdata[146:115];
   assign w1       = (w_raw != '0) ? w_raw : 14'd1;
   assign len1     = (len_raw != '0) ? len_raw : bcr_pkg::SLICE_P_NS;
   assign idle_c   = (idle_raw > bcr_pkg::IDLE_CLAMP) ? bcr_pkg::IDLE_CLAMP[29:0]
                                                      : idle_raw[29:0];

   always_ff @(posedge clock) begin
      if (adv) begin
         wsp_ff   <= 39'(w1) * 39'(bcr_pkg::SLICE_P_NS);
         costp_ff <= 41'(cp) * 41'(len1);
         coste_ff <= 41'(ce) * 41'(len1);
         rprod_ff <= 44'(idle_c) * 44'(w1);
         wake_ff  <= req_tuser[0] && (idle_raw != '0);
         lp2_ff   <= len1 > bcr_pkg::SLICE_P_NS;
         bud1_ff  <= req_tdata[76:39];
         cap1_ff  <= req_tdata[114:77];
      end
   end

   // stage 2: refill, P value, divider operands
   logic [38:0]  bsum;
   logic [37:0]  bud2;
   logic [49:0]  wmc_ff;
   logic [12:0]  cdiv_ff;
   bcr_pkg::side_type s2_ff;
   bcr_pkg::side_type dly_ff [bcr_pkg::DIV_STAGES];

   assign bsum = 39'(bud1_ff) + 39'(rprod_ff[43:14]);
   assign bud2 = !wake_ff ? bud1_ff : ((bsum > 39'(cap1_ff)) ? cap1_ff : bsum[37:0]);

   always_ff @(posedge clock) begin
      if (adv) begin
         wmc_ff       <= 50'(wsp_ff) * 50'(mc);
         cdiv_ff      <= (lp2_ff ? {1'b0, mx, 1'b0} : 13'(mx)) + 13'(mc) - 13'd1;
         s2_ff.phi_p  <= $signed(43'(wsp_ff)) - $signed({2'b0, costp_ff});
         s2_ff.cost_e <= coste_ff;
         s2_ff.lp2    <= lp2_ff;
         s2_ff.budget <= bud2;
         s2_ff.cap    <= cap1_ff;
      end
   end

   logic [bcr_pkg::WDIV_W-1:0] wse;
   logic [bcr_pkg::CDIV_W-1:0] cq;

   bcr_div #(.DW(bcr_pkg::WDIV_W), .STAGES(bcr_pkg::DIV_STAGES)) u_wdiv (
      .clock    (clock),
      .adv      (adv),
      .dividend (wmc_ff),
      .divisor  (mx),
      .quotient (wse)
   );

   bcr_div #(.DW(bcr_pkg::CDIV_W), .STAGES(bcr_pkg::DIV_STAGES)) u_cdiv (
      .clock    (clock),
      .adv      (adv),
      .dividend (cdiv_ff),
      .divisor  (mc),
      .quotient (cq)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_ff[0] <= s2_ff;
         for (int i = 1; i < bcr_pkg::DIV_STAGES; i++) begin
            dly_ff[i] <= dly_ff[i-1];
         end
      end
   end

   // stage 16: E value, starvation
   bcr_pkg::side_type sd;
   logic signed [51:0] phip16_ff, phie16_ff;
   logic [12:0] cq16_ff;
   logic        lp2_16_ff, starved16_ff;
   logic [37:0] bud16_ff;

   assign sd = dly_ff[bcr_pkg::DIV_STAGES-1];

   always_ff @(posedge clock) begin
      if (adv) begin
         phip16_ff    <= 52'($signed(sd.phi_p));
         phie16_ff    <= $signed({2'b0, wse}) - $signed({11'b0, sd.cost_e});
         cq16_ff      <= cq;
         lp2_16_ff    <= sd.lp2;
         starved16_ff <= (sd.cap != '0) && ((42'(sd.budget) * 42'd10) < 42'(sd.cap));
         bud16_ff     <= sd.budget;
      end
   end

   // stage 17: choice, saturation, contract
   logic               on_p;
   logic signed [51:0] phi;
   logic [12:0]        m_raw;
   logic               on_p17_ff, starved17_ff;
   logic signed [42:0] bid17_ff;
   logic [12:0]        m17_ff;
   logic [37:0]        bud17_ff;

   assign on_p  = phip16_ff >= phie16_ff;
   assign phi   = on_p ? phip16_ff : phie16_ff;
   assign m_raw = on_p ? (lp2_16_ff ? 13'd2 : 13'd1) : cq16_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         on_p17_ff    <= on_p;
         starved17_ff <= starved16_ff;
         priority if (phi > bcr_pkg::BID_MAX) bid17_ff <= bcr_pkg::BID_MAX[42:0];
         else if (phi < bcr_pkg::BID_MIN)     bid17_ff <= bcr_pkg::BID_MIN[42:0];
         else                                 bid17_ff <= phi[42:0];
         m17_ff   <= (m_raw >= M_SAT) ? M_SAT : m_raw;
         bud17_ff <= bud16_ff;
      end
   end

   // stage 18: output register
   logic [151:0] rdata_ff;
   logic [3:0]   ruser_ff;
   bcr_pkg::queue_type queue;

   always_comb begin
      priority if (starved17_ff) queue = bcr_pkg::Q_STARVED;
      else if (on_p17_ff)        queue = bcr_pkg::Q_PERF;
      else                       queue = bcr_pkg::Q_EFF;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rdata_ff <= {3'b0, bud17_ff,
                      bcr_pkg::KEY_BIAS - {{20{bid17_ff[42]}}, bid17_ff},
                      m17_ff[4:0], bid17_ff};
         ruser_ff <= {!on_p17_ff && !starved17_ff, queue, on_p17_ff};
      end
   end

   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;

endmodule

`default_nettype wire

[src/bcr_chk.sv]
// ----------------------------------------------------------------------------
// bcr_chk
// Port-level checks of the task bid cluster router.
// ----------------------------------------------------------------------------
`default_nettype none

module bcr_chk (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [151:0] rsp_tdata,
   input wire logic [3:0]   rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled item changed");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input taken while output stalled");

   a_queue_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[2:1] != 2'd3 &&
                     (!rsp_tuser[3] || (rsp_tuser[2:1] == 2'd1 && !rsp_tuser[0])))
      else $error("queue and slice class disagree");

endmodule

bind task_bid_cluster_router bcr_chk u_bcr_chk (.*);

`default_nettype wire
